>>> design/slt_pkg.sv
// sequential list table package: sizes, operation codes and shared types
// used by sequential_list_table; depends on nothing
package slt_pkg;

	localparam int CAPACITY   = 64;
	localparam int ELEM_WIDTH = 32;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int OP_W       = 3;
	localparam int POS_W      = 7;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OP_W-1:0] OP_GET    = 3'd2;
	localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	typedef logic [ELEM_WIDTH-1:0] elem_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [CNT_W-1:0]      cnt_t;

endpackage

>>> design/sequential_list_table.sv
// clear and rejected items strobe done in the cycle after accept; get reads, then strobes;
// insert shifts entries up, then writes the value (at once when appending); delete shifts
// later entries down; locate scans to a match or the end; one item at a time: busy stays
// high until the result strobe; the memory moving one entry per cycle sets the rate;
// results cannot be stalled; reset clears the count and the fsm, list slots are not cleared
// top level of the sequential list table; depends on slt_pkg
module sequential_list_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [slt_pkg::OP_W-1:0]       operation,
	input  logic [slt_pkg::POS_W-1:0]      position,
	input  logic signed [slt_pkg::ELEM_WIDTH-1:0] value,
	output logic                           done,
	output logic                           ok,
	output logic signed [slt_pkg::ELEM_WIDTH-1:0] element,
	output logic [slt_pkg::POS_W-1:0]      found_at,
	output logic [slt_pkg::POS_W-1:0]      count,
	output logic                           is_empty
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INS  = 3'd1;
	localparam logic [2:0] ST_DEL  = 3'd2;
	localparam logic [2:0] ST_GET  = 3'd3;
	localparam logic [2:0] ST_LOC  = 3'd4;

	slt_pkg::elem_t mem [slt_pkg::CAPACITY];
	slt_pkg::elem_t rdata_s1;

	logic [2:0]                  state_q;
	slt_pkg::cnt_t               fill_q;
	slt_pkg::cnt_t               k_q;
	logic [slt_pkg::POS_W-1:0]   pos_q;
	slt_pkg::elem_t              val_q;
	logic                        pend_s1;
	logic                        cap_s1;
	slt_pkg::addr_t              tgt_s1;
	logic                        done_q;
	logic                        ok_q;
	slt_pkg::elem_t              element_q;
	logic [slt_pkg::POS_W-1:0]   found_q;

	logic                        accept;
	logic                        ins_ok;
	logic                        pos_ok;
	logic [slt_pkg::POS_W-1:0]   pos_m1;
	logic                        ren;
	slt_pkg::addr_t              raddr;
	logic                        we;
	slt_pkg::addr_t              waddr;
	slt_pkg::elem_t              wdata;
	logic                        finish;
	logic                        match;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign pos_m1 = pos_q - 7'd1;

	// position checks against the current count
	assign ins_ok = (position != '0)
		&& ({1'b0, position} <= ({1'b0, slt_pkg::POS_W'(fill_q)} + 8'd1))
		&& (fill_q < slt_pkg::CNT_W'(slt_pkg::CAPACITY));
	assign pos_ok = (position != '0) && (position <= slt_pkg::POS_W'(fill_q));

	assign match = pend_s1 && (rdata_s1 == val_q);

	always_comb begin
		ren    = 1'b0;
		raddr  = k_q[slt_pkg::ADDR_W-1:0];
		we     = 1'b0;
		waddr  = tgt_s1;
		wdata  = rdata_s1;
		finish = 1'b0;
		case (state_q)
			ST_INS: begin
				// walk down from the end, moving entry k-1 to k
				ren   = (k_q >= slt_pkg::CNT_W'(pos_q));
				raddr = slt_pkg::ADDR_W'(k_q - 1'b1);
				if (pend_s1) begin
					we = 1'b1;
				end else if (!ren) begin
					we     = 1'b1;
					waddr  = slt_pkg::ADDR_W'(pos_m1);
					wdata  = val_q;
					finish = 1'b1;
				end
			end
			ST_DEL: begin
				// walk up, the first read is the removed element
				ren    = (k_q < fill_q);
				we     = pend_s1 && !cap_s1;
				finish = !ren && !pend_s1;
			end
			ST_GET: begin
				ren    = !pend_s1;
				finish = pend_s1;
			end
			ST_LOC: begin
				ren    = (k_q < fill_q) && !match;
				finish = match || (!pend_s1 && (k_q >= fill_q));
			end
			default: begin
				ren = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			pend_s1 <= ren;
			if (accept) begin
				case (operation)
					slt_pkg::OP_INSERT: begin
						if (ins_ok) state_q <= ST_INS;
						else done_q <= 1'b1;
					end
					slt_pkg::OP_DELETE: begin
						if (pos_ok) state_q <= ST_DEL;
						else done_q <= 1'b1;
					end
					slt_pkg::OP_GET: begin
						if (pos_ok) state_q <= ST_GET;
						else done_q <= 1'b1;
					end
					slt_pkg::OP_LOCATE: begin
						state_q <= ST_LOC;
					end
					slt_pkg::OP_CLEAR: begin
						fill_q <= '0;
						done_q <= 1'b1;
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end else if (finish) begin
				state_q <= ST_IDLE;
				done_q  <= 1'b1;
				if (state_q == ST_INS) begin
					fill_q <= fill_q + 1'b1;
				end else if (state_q == ST_DEL) begin
					fill_q <= fill_q - 1'b1;
				end
			end
		end
	end

	// walk pointer and item fields
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q     <= position;
			val_q     <= value;
			element_q <= '0;
			found_q   <= '0;
			cap_s1    <= 1'b0;
			case (operation)
				slt_pkg::OP_INSERT: begin
					ok_q <= ins_ok;
					k_q  <= fill_q;
				end
				slt_pkg::OP_DELETE: begin
					ok_q <= pos_ok;
					k_q  <= slt_pkg::CNT_W'(position - 7'd1);
				end
				slt_pkg::OP_GET: begin
					ok_q <= pos_ok;
					k_q  <= slt_pkg::CNT_W'(position - 7'd1);
				end
				slt_pkg::OP_LOCATE: begin
					ok_q <= 1'b1;
					k_q  <= '0;
				end
				slt_pkg::OP_CLEAR: begin
					ok_q <= 1'b1;
				end
				default: begin
					ok_q <= 1'b0;
				end
			endcase
		end else begin
			case (state_q)
				ST_INS: begin
					if (ren) begin
						k_q    <= k_q - 1'b1;
						tgt_s1 <= k_q[slt_pkg::ADDR_W-1:0];
					end
				end
				ST_DEL: begin
					if (ren) begin
						k_q    <= k_q + 1'b1;
						tgt_s1 <= slt_pkg::ADDR_W'(k_q - 1'b1);
						cap_s1 <= (k_q == slt_pkg::CNT_W'(pos_m1));
					end
					if (pend_s1 && cap_s1) begin
						element_q <= rdata_s1;
					end
				end
				ST_GET: begin
					if (pend_s1) begin
						element_q <= rdata_s1;
					end
				end
				ST_LOC: begin
					if (ren) begin
						k_q    <= k_q + 1'b1;
						tgt_s1 <= k_q[slt_pkg::ADDR_W-1:0];
					end
					if (match) begin
						found_q <= slt_pkg::POS_W'(tgt_s1) + 7'd1;
					end
				end
				default: begin
					cap_s1 <= 1'b0;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign ok       = ok_q;
	assign element  = element_q;
	assign found_at = found_q;
	assign count    = slt_pkg::POS_W'(fill_q);
	assign is_empty = (fill_q == '0);

endmodule

>>> test/tb_sequential_list_table.sv
// self-checking testbench for sequential_list_table: directed and random list requests,
// a shadow copy of the list predicts every reply; depends on slt_pkg and the rtl top
module tb_sequential_list_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 550;
	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 80;
	localparam int CALM_TAIL    = 80;
	localparam int PRINT_CAP    = 40;

	typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_t;

	typedef struct {
		logic [slt_pkg::OP_W-1:0]  op;
		logic [slt_pkg::POS_W-1:0] pos;
		slt_pkg::elem_t            val;
	} list_cmd_t;

	typedef struct {
		logic                      ok;
		slt_pkg::elem_t            element;
		logic [slt_pkg::POS_W-1:0] found_at;
		logic [slt_pkg::POS_W-1:0] count;
		logic                      is_empty;
	} list_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [slt_pkg::OP_W-1:0] operation = '0;
	logic [slt_pkg::POS_W-1:0] position = '0;
	slt_pkg::elem_t value = '0;
	logic busy, done, ok, is_empty;
	slt_pkg::elem_t element;
	logic [slt_pkg::POS_W-1:0] found_at, count;

	sequential_list_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.position(position),
		.value(value),
		.done(done),
		.ok(ok),
		.element(element),
		.found_at(found_at),
		.count(count),
		.is_empty(is_empty)
	);

	list_cmd_t   cmd_queue[$];
	list_reply_t owed_replies[$];
	list_cmd_t   cur_cmd;

	// shadow copy of the list, updated when an item is accepted
	slt_pkg::elem_t shadow_list[slt_pkg::CAPACITY];
	int    shadow_len = 0;

	// fill count as the generator sees it, used to aim positions
	int    gen_fill = 0;
	slt_pkg::elem_t value_pool[8];

	int mismatches = 0;
	int items_taken = 0;
	int replies_checked = 0;
	int full_refusals = 0;
	int locate_hits = 0;
	int idle_left = 0;
	int calm_left = 0;
	int quiet_cycles = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [63:0] seen,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch %s at %0t: got %0h want %0h", what, $time, seen, want);
	endtask

	task automatic apply_list_op(input list_cmd_t c);
		list_reply_t r;
		int p;
		int k;
		r = '{default: '0};
		p = int'(c.pos);
		case (c.op)
			slt_pkg::OP_INSERT: begin
				if (shadow_len == slt_pkg::CAPACITY) begin
					full_refusals++;
				end else if (p >= 1 && p <= shadow_len + 1) begin
					for (k = shadow_len; k > p - 1; k--)
						shadow_list[k] = shadow_list[k-1];
					shadow_list[p-1] = c.val;
					shadow_len++;
					r.ok = 1'b1;
				end
			end
			slt_pkg::OP_DELETE: begin
				if (p >= 1 && p <= shadow_len) begin
					r.element = shadow_list[p-1];
					for (k = p - 1; k + 1 < shadow_len; k++)
						shadow_list[k] = shadow_list[k+1];
					shadow_len--;
					r.ok = 1'b1;
				end
			end
			slt_pkg::OP_GET: begin
				if (p >= 1 && p <= shadow_len) begin
					r.element = shadow_list[p-1];
					r.ok = 1'b1;
				end
			end
			slt_pkg::OP_LOCATE: begin
				r.ok = 1'b1;
				for (k = 0; k < shadow_len; k++) begin
					if (shadow_list[k] == c.val && r.found_at == '0) begin
						r.found_at = slt_pkg::POS_W'(k + 1);
						locate_hits++;
					end
				end
			end
			slt_pkg::OP_CLEAR: begin
				shadow_len = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.count = slt_pkg::POS_W'(shadow_len);
		r.is_empty = (shadow_len == 0);
		owed_replies.push_back(r);
	endtask

	task automatic queue_cmd(input logic [slt_pkg::OP_W-1:0] op,
			input logic [slt_pkg::POS_W-1:0] pos, input slt_pkg::elem_t val);
		int p;
		list_cmd_t c;
		p = int'(pos);
		c.op = op;
		c.pos = pos;
		c.val = val;
		cmd_queue.push_back(c);
		case (op)
			slt_pkg::OP_INSERT:
				if (p >= 1 && p <= gen_fill + 1 && gen_fill < slt_pkg::CAPACITY) gen_fill++;
			slt_pkg::OP_DELETE: if (p >= 1 && p <= gen_fill) gen_fill--;
			slt_pkg::OP_CLEAR:  gen_fill = 0;
			default: ;
		endcase
	endtask

	function automatic logic [slt_pkg::POS_W-1:0] pick_pos(
			input logic [slt_pkg::OP_W-1:0] op);
		int top;
		int r;
		top = (op == slt_pkg::OP_INSERT) ? gen_fill + 1 : gen_fill;
		r = $urandom_range(0, 99);
		if (r < 6)
			return '0;
		if (r < 14)
			return slt_pkg::POS_W'($urandom_range((top < 65) ? top + 1 : 65, 65));
		if (top == 0)
			return slt_pkg::POS_W'($urandom_range(0, 65));
		if (r < 24)
			return slt_pkg::POS_W'(1);
		if (r < 34)
			return slt_pkg::POS_W'(top);
		return slt_pkg::POS_W'($urandom_range(1, top));
	endfunction

	function automatic slt_pkg::elem_t pick_value();
		if ($urandom_range(0, 99) < 50)
			return value_pool[$urandom_range(0, 7)];
		return slt_pkg::elem_t'($urandom);
	endfunction

	task automatic queue_random(input mix_t mode);
		int r;
		logic [slt_pkg::OP_W-1:0] op;
		r = $urandom_range(0, 99);
		case (mode)
			MIX_GROW:
				op = (r < 75) ? slt_pkg::OP_INSERT : (r < 80) ? slt_pkg::OP_DELETE :
					(r < 90) ? slt_pkg::OP_GET : slt_pkg::OP_LOCATE;
			MIX_SHRINK:
				op = (r < 10) ? slt_pkg::OP_INSERT : (r < 70) ? slt_pkg::OP_DELETE :
					(r < 82) ? slt_pkg::OP_GET : (r < 97) ? slt_pkg::OP_LOCATE :
					slt_pkg::OP_CLEAR;
			default:
				op = (r < 35) ? slt_pkg::OP_INSERT : (r < 60) ? slt_pkg::OP_DELETE :
					(r < 80) ? slt_pkg::OP_GET : (r < 97) ? slt_pkg::OP_LOCATE :
					slt_pkg::OP_CLEAR;
		endcase
		if (op == slt_pkg::OP_LOCATE || op == slt_pkg::OP_CLEAR)
			queue_cmd(op, slt_pkg::POS_W'($urandom_range(0, 65)), pick_value());
		else
			queue_cmd(op, pick_pos(op), pick_value());
	endtask

	// driver: one item presented at a time, held until busy is low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			idle_left = 0;
		end else begin
			if (start && !busy) begin
				apply_list_op(cur_cmd);
				items_taken++;
				if (cmd_queue.size() > CALM_TAIL) begin
					if (calm_left > 0) begin
						calm_left--;
					end else begin
						case ($urandom_range(0, 9))
							0:       calm_left = $urandom_range(20, 60);
							1, 2, 3: idle_left = $urandom_range(1, 15);
							default: ;
						endcase
					end
				end
			end
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					cur_cmd = cmd_queue.pop_front();
					operation <= cur_cmd.op;
					position <= cur_cmd.pos;
					value <= cur_cmd.val;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobed reply is matched against the oldest owed one
	always @(posedge clk) begin
		list_reply_t want;
		if (arst_n && done) begin
			if (owed_replies.size() == 0) begin
				report_mismatch("reply with none owed", {63'd0, ok}, 64'd0);
			end else begin
				want = owed_replies.pop_front();
				replies_checked++;
				if (ok !== want.ok)
					report_mismatch("ok", 64'(ok), 64'(want.ok));
				if (element !== want.element)
					report_mismatch("element", 64'(element), 64'(want.element));
				if (found_at !== want.found_at)
					report_mismatch("found_at", 64'(found_at), 64'(want.found_at));
				if (count !== want.count)
					report_mismatch("count", 64'(count), 64'(want.count));
				if (is_empty !== want.is_empty)
					report_mismatch("is_empty", 64'(is_empty), 64'(want.is_empty));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int k;
		mix_t mode;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = '0;
		value_pool[3] = '1;
		for (k = 4; k < 8; k++)
			value_pool[k] = slt_pkg::elem_t'($urandom);

		// empty list, bad positions, extremes, duplicates, ends of the list
		queue_cmd(slt_pkg::OP_GET, 7'd1, '0);
		queue_cmd(slt_pkg::OP_DELETE, 7'd1, '0);
		queue_cmd(slt_pkg::OP_LOCATE, 7'd0, '0);
		queue_cmd(slt_pkg::OP_INSERT, 7'd0, 32'h1234_5678);
		queue_cmd(slt_pkg::OP_INSERT, 7'd2, 32'h1234_5678);
		queue_cmd(slt_pkg::OP_INSERT, 7'd1, 32'h8000_0000);
		queue_cmd(slt_pkg::OP_INSERT, 7'd2, 32'h7fff_ffff);
		queue_cmd(slt_pkg::OP_INSERT, 7'd1, 32'hffff_ffff);
		queue_cmd(slt_pkg::OP_INSERT, 7'd4, 32'hffff_ffff);
		queue_cmd(slt_pkg::OP_INSERT, 7'd3, 32'h0000_0000);
		queue_cmd(slt_pkg::OP_LOCATE, 7'd0, 32'hffff_ffff);
		queue_cmd(slt_pkg::OP_LOCATE, 7'd65, 32'h7fff_ffff);
		queue_cmd(slt_pkg::OP_LOCATE, 7'd3, 32'h0000_0005);
		queue_cmd(slt_pkg::OP_GET, 7'd5, '0);
		queue_cmd(slt_pkg::OP_GET, 7'd6, '0);
		queue_cmd(slt_pkg::OP_GET, 7'd65, '0);
		queue_cmd(slt_pkg::OP_DELETE, 7'd65, '0);
		queue_cmd(slt_pkg::OP_DELETE, 7'd5, '0);
		queue_cmd(slt_pkg::OP_DELETE, 7'd1, '0);
		queue_cmd(slt_pkg::OP_DELETE, 7'd0, '0);
		queue_cmd(slt_pkg::OP_INSERT, 7'd65, 32'h0000_0001);
		queue_cmd(slt_pkg::OP_CLEAR, 7'd0, '0);
		queue_cmd(slt_pkg::OP_GET, 7'd1, '0);
		queue_cmd(slt_pkg::OP_CLEAR, 7'd64, '1);

		// fill the list to capacity, then push against the full list
		n = 0;
		while (gen_fill < slt_pkg::CAPACITY) begin
			queue_random(MIX_GROW);
			n++;
		end
		queue_cmd(slt_pkg::OP_INSERT, 7'd65, pick_value());
		queue_cmd(slt_pkg::OP_INSERT, 7'd1, pick_value());
		queue_cmd(slt_pkg::OP_INSERT, pick_pos(slt_pkg::OP_INSERT), pick_value());
		n += 3;
		while (n < RANDOM_ITEMS) begin
			mode = mix_t'($urandom_range(0, 2));
			repeat (40) queue_random(mode);
			n += 40;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (cmd_queue.size() != 0 || start)
			@(negedge clk);
		while (owed_replies.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d requests accepted, %0d replies checked", items_taken, replies_checked);
		$display("%0d inserts refused on a full list, %0d locate hits", full_refusals,
			locate_hits);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
design/slt_pkg.sv
design/sequential_list_table.sv
test/tb_sequential_list_table.sv
